>>> rtl/core/hhlp_pkg.sv
// hhlp_pkg: types, codes and constants for the HTTP header line parser.
// No dependencies; imported by hhlp_fsm and http_header_line_parser.
package hhlp_pkg;

	localparam int BYTE_W  = 8;
	localparam int KEY_W   = 10;
	localparam int VAL_W   = 11;
	localparam int LIMIT_W = 10;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	localparam logic [KEY_W-1:0]   KEY_MAX     = 10'd1023;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd255;

	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

	// register index of value_offset_limit (paddr bit 2 and up)
	localparam logic REG_VALUE_LIMIT = 1'b0;

	typedef enum logic [3:0] {
		PH_START  = 4'd0,
		PH_KEY    = 4'd1,
		PH_COLON  = 4'd2,
		PH_SPACE  = 4'd3,
		PH_VALUE  = 4'd4,
		PH_CR     = 4'd5,
		PH_LF     = 4'd6,
		PH_END_CR = 4'd7,
		PH_DONE   = 4'd8,
		PH_ERROR  = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		K_FRAME   = 3'd0,
		K_KEY     = 3'd1,
		K_VALUE   = 3'd2,
		K_HEADER  = 3'd3,
		K_END     = 3'd4,
		K_ERROR   = 3'd5,
		K_STOPPED = 3'd6
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              new_request;
	} req_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] byte_echo;
		logic [KEY_W-1:0]  key_length;
		logic [VAL_W-1:0]  value_length;
	} rsp_t;

endpackage

>>> rtl/core/hhlp_fsm.sv
// hhlp_fsm: line state machine and key/value counters; classifies one byte per step.
// Depends on hhlp_pkg.
module hhlp_fsm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  hhlp_pkg::req_t               req,
	input  logic [hhlp_pkg::LIMIT_W-1:0] limit,
	output hhlp_pkg::rsp_t               rsp
);
	import hhlp_pkg::*;

	phase_t             phase_q, phase_cur, phase_nxt;
	logic [KEY_W-1:0]   key_q, key_cur, key_nxt;
	logic [VAL_W-1:0]   val_q, val_cur, val_nxt;
	logic [BYTE_W-1:0]  b;
	logic               is_crlf;
	logic               val_over;

	// new_request restarts the line before this byte
	assign phase_cur = req.new_request ? PH_START : phase_q;
	assign key_cur   = req.new_request ? '0 : key_q;
	assign val_cur   = req.new_request ? '0 : val_q;
	assign b         = req.data_byte;
	assign is_crlf   = (b == CH_CR) || (b == CH_LF);
	assign val_over  = val_cur > {1'b0, limit};

	// next state
	always_comb begin
		phase_nxt = phase_cur;
		key_nxt   = key_cur;
		val_nxt   = val_cur;
		case (phase_cur)
			PH_START: begin
				if (!is_crlf) begin
					phase_nxt = PH_KEY;
					key_nxt   = KEY_W'(1);
					val_nxt   = '0;
				end
			end
			PH_KEY: begin
				if (b == CH_COLON) begin
					phase_nxt = PH_COLON;
				end else if (is_crlf) begin
					phase_nxt = PH_ERROR;
				end else if (key_cur < KEY_MAX) begin
					key_nxt = key_cur + KEY_W'(1);
				end
			end
			PH_COLON: begin
				phase_nxt = (b == CH_SPACE) ? PH_SPACE : PH_ERROR;
			end
			PH_SPACE: begin
				phase_nxt = PH_VALUE;
				val_nxt   = VAL_W'(1);
			end
			PH_VALUE: begin
				if (b == CH_CR) begin
					phase_nxt = PH_CR;
				end else if (val_over) begin
					phase_nxt = PH_ERROR;
				end else begin
					val_nxt = val_cur + VAL_W'(1);
				end
			end
			PH_CR: begin
				phase_nxt = (b == CH_LF) ? PH_LF : PH_ERROR;
			end
			PH_LF: begin
				if (b == CH_CR) begin
					phase_nxt = PH_END_CR;
				end else begin
					phase_nxt = PH_KEY;
					key_nxt   = KEY_W'(1);
					val_nxt   = '0;
				end
			end
			PH_END_CR: begin
				phase_nxt = (b == CH_LF) ? PH_DONE : PH_ERROR;
			end
			default: begin
				phase_nxt = phase_cur;
			end
		endcase
	end

	// outputs
	always_comb begin
		rsp.kind         = K_FRAME;
		rsp.byte_echo    = b;
		rsp.key_length   = '0;
		rsp.value_length = '0;
		case (phase_cur)
			PH_START: begin
				rsp.kind = is_crlf ? K_FRAME : K_KEY;
			end
			PH_KEY: begin
				if (b == CH_COLON) begin
					rsp.kind = K_FRAME;
				end else if (is_crlf) begin
					rsp.kind = K_ERROR;
				end else begin
					rsp.kind = K_KEY;
				end
			end
			PH_COLON: begin
				rsp.kind = (b == CH_SPACE) ? K_FRAME : K_ERROR;
			end
			PH_SPACE: begin
				rsp.kind = K_VALUE;
			end
			PH_VALUE: begin
				if (b == CH_CR) begin
					rsp.kind = K_FRAME;
				end else if (val_over) begin
					rsp.kind = K_ERROR;
				end else begin
					rsp.kind = K_VALUE;
				end
			end
			PH_CR: begin
				if (b == CH_LF) begin
					rsp.kind         = K_HEADER;
					rsp.key_length   = key_cur;
					rsp.value_length = val_cur;
				end else begin
					rsp.kind = K_ERROR;
				end
			end
			PH_LF: begin
				rsp.kind = (b == CH_CR) ? K_FRAME : K_KEY;
			end
			PH_END_CR: begin
				rsp.kind = (b == CH_LF) ? K_END : K_ERROR;
			end
			default: begin
				rsp.kind = K_STOPPED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			key_q   <= '0;
			val_q   <= '0;
		end else if (step) begin
			phase_q <= phase_nxt;
			key_q   <= key_nxt;
			val_q   <= val_nxt;
		end
	end

endmodule

>>> rtl/core/http_header_line_parser.sv
// http_header_line_parser: top level; request/result pipeline registers and APB register.
// Depends on hhlp_pkg and hhlp_fsm.
//
// Takes HTTP header bytes one per request and returns one classification per byte
// (framing, key byte, value byte, header done with key/value lengths, headers end,
// error, stopped). Throughput is one byte per clock while rsp_stall is low: the line
// state machine and its counters are the one loop that sets the rate. Each byte is
// held in the request register, then its result in the result register.
// After headers end or an error every byte reports stopped
// until a request arrives with new_request set. value_offset_limit sits at APB
// byte address 0 and should only be written while no bytes are in flight.
module http_header_line_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  hhlp_pkg::req_t              req,
	// result channel
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output hhlp_pkg::rsp_t              rsp,
	// APB configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hhlp_pkg::APB_AW-1:0] paddr,
	input  logic [hhlp_pkg::APB_DW-1:0] pwdata,
	output logic [hhlp_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import hhlp_pkg::*;

	logic               valid_s1;
	req_t               req_s1;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	rsp_t               fsm_rsp;
	logic [LIMIT_W-1:0] limit_q;
	logic               s2_ready;
	logic               advance;
	logic               accept;
	logic               cfg_wr;

	// result register frees when empty or drained this cycle
	assign s2_ready  = !rsp_valid_q || !rsp_stall;
	assign advance   = valid_s1 && s2_ready;
	assign req_stall = valid_s1 && !s2_ready;
	assign accept    = req_valid && !req_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// --- APB: single register, pready tied high ---
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_VALUE_LIMIT);
	assign prdata = (paddr[APB_AW-1:2] == REG_VALUE_LIMIT) ?
	                {{(APB_DW-LIMIT_W){1'b0}}, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// --- stage 1: request register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// --- parser: state steps as the byte moves to the result register ---
	hhlp_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.limit  (limit_q),
		.rsp    (fsm_rsp)
	);

	// --- stage 2: result register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (s2_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= fsm_rsp;
		end
	end

`ifndef ASSERT_OFF
	// a completed header always has a non-empty key and value
	a_header_lengths: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == K_HEADER) |-> (rsp.key_length != '0) &&
		(rsp.value_length != '0))
		else $error("header done with an empty key or value");

	// lengths are reported only with header done
	a_lengths_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind != K_HEADER) |-> (rsp.key_length == '0) &&
		(rsp.value_length == '0))
		else $error("lengths reported outside header done");

	// back-pressure only while the request register holds a byte
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid_q && rsp_stall)
		else $error("request stalled with room in the pipeline");

	// a byte leaving stage 1 shows up as a result next cycle
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid)
		else $error("advanced byte produced no result");
`endif

endmodule
